/* design/chacha_pkg.sv */
// shared types, constants and helpers for the chacha20 stream cipher
`default_nettype none
package chacha_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned LANE_W    = 32;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned QR_STEPS  = 80;
  localparam int unsigned STEP_W    = 7;

  typedef logic [LANE_W-1:0] lane_t;

  localparam lane_t SIGMA0 = 32'h6170_7865;
  localparam lane_t SIGMA1 = 32'h3320_646e;
  localparam lane_t SIGMA2 = 32'h7962_2d32;
  localparam lane_t SIGMA3 = 32'h6b20_6574;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_NONCE0 = 3'd4,
    CFG_NONCE1 = 3'd5,
    CFG_START  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic add;
  } blk_ctrl_t;

  typedef struct packed {
    logic last_step;
  } blk_stat_t;

  function automatic lane_t rotl(lane_t v, int unsigned k);
    return (v << k) | (v >> (LANE_W - k));
  endfunction

endpackage
`default_nettype wire

/* design/chacha_if.sv */
// request channel interfaces: message in, result out, register writes
`default_nettype none
interface chacha_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count, output last_word,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last_word,
                  output ready);
endinterface

interface chacha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic [3:0]  out_byte_count;
  logic        out_last;

  modport source (output valid, output out_word, output out_byte_count, output out_last,
                  input ready);
  modport sink   (input valid, input out_word, input out_byte_count, input out_last,
                  output ready);
endinterface

interface chacha_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/chacha_qr.sv */
// chacha quarter-round unit, one full quarter-round per use
`default_nettype none
module chacha_qr (
  input  chacha_pkg::lane_t a_in,
  input  chacha_pkg::lane_t b_in,
  input  chacha_pkg::lane_t c_in,
  input  chacha_pkg::lane_t d_in,
  output chacha_pkg::lane_t a_out,
  output chacha_pkg::lane_t b_out,
  output chacha_pkg::lane_t c_out,
  output chacha_pkg::lane_t d_out
);
  import chacha_pkg::*;

  lane_t a1, b1, c1, d1;
  lane_t a2, b2, c2, d2;

  always_comb begin
    a1 = a_in + b_in;
    d1 = rotl(d_in ^ a1, 16);
    c1 = c_in + d1;
    b1 = rotl(b_in ^ c1, 12);
    a2 = a1 + b1;
    d2 = rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = rotl(b1 ^ c2, 7);
  end

  assign a_out = a2;
  assign b_out = b2;
  assign c_out = c2;
  assign d_out = d2;

endmodule
`default_nettype wire

/* design/chacha_block.sv */
// working words, round step counter and add-back for one keystream block
`default_nettype none
module chacha_block (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chacha_pkg::blk_ctrl_t ctrl,
  input  logic [15:0][31:0]     init_words,
  input  logic [2:0]            pos,
  output chacha_pkg::blk_stat_t stat,
  output logic [63:0]           ks_word
);
  import chacha_pkg::*;

  lane_t words_r   [16];
  lane_t words_nxt [16];
  lane_t mixed     [16];
  logic [STEP_W-1:0] step_r, step_nxt;
  logic  diag;
  lane_t qa, qb, qc, qd;
  lane_t ra, rb, rc, rd;

  // rows rotate left after every step, so the unit always sees fixed taps
  assign diag = step_r[2];
  assign qa   = words_r[0];
  assign qb   = diag ? words_r[5]  : words_r[4];
  assign qc   = diag ? words_r[10] : words_r[8];
  assign qd   = diag ? words_r[15] : words_r[12];

  chacha_qr u_qr (
    .a_in (qa), .b_in (qb), .c_in (qc), .d_in (qd),
    .a_out(ra), .b_out(rb), .c_out(rc), .d_out(rd)
  );

  always_comb begin
    mixed    = words_r;
    mixed[0] = ra;
    if (diag) begin
      mixed[5]  = rb;
      mixed[10] = rc;
      mixed[15] = rd;
    end else begin
      mixed[4]  = rb;
      mixed[8]  = rc;
      mixed[12] = rd;
    end
  end

  always_comb begin
    words_nxt = words_r;
    step_nxt  = step_r;
    if (ctrl.load) begin
      for (int i = 0; i < 16; i++) begin
        words_nxt[i] = init_words[i];
      end
      step_nxt = '0;
    end else if (ctrl.step) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          words_nxt[4*r + c] = mixed[4*r + ((c + 1) % 4)];
        end
      end
      step_nxt = step_r + STEP_W'(1);
    end else if (ctrl.add) begin
      for (int i = 0; i < 16; i++) begin
        words_nxt[i] = words_r[i] + init_words[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign stat.last_step = (step_r == STEP_W'(QR_STEPS - 1));
  assign ks_word        = {words_r[{pos, 1'b1}], words_r[{pos, 1'b0}]};

endmodule
`default_nettype wire

/* design/chacha20_stream_cipher.sv */
// chacha20 stream cipher top level: registers, sequencer and output stage
//
//  channel  dir  payload                                     accepted when
//  in_ch    in   data_word[64] byte_count[4] last_word[1]    valid & ready
//  out_ch   out  out_word[64] out_byte_count[4] out_last[1]  valid & ready
//  cfg_ch   in   index[3] data[64]                           valid & ready
//
//  a word at block position zero is taken in ST_IDLE, then gets 80 quarter-rounds
//  on the one shared quarter-round unit in ST_ROUND, the add-back in ST_ADD
//  and its result in ST_EMIT; other words go from ST_IDLE straight to ST_EMIT
//  reset clears config and control, back to message start; cfg_ch is always ready
//  the result waits in an output register; the next word is taken meanwhile
`default_nettype none
module chacha20_stream_cipher (
  input  logic          clk,
  input  logic          rst_n,
  chacha_in_if.sink     in_ch,
  chacha_out_if.source  out_ch,
  chacha_cfg_if.sink    cfg_ch
);
  import chacha_pkg::*;

  logic [WORD_W-1:0]  key_r [4];
  logic [WORD_W-1:0]  nonce_lo_r;
  lane_t              nonce_hi_r;
  lane_t              start_r;

  state_t             state_r, state_nxt;
  blk_ctrl_t          ctrl;
  blk_stat_t          stat;
  logic               in_ready;
  logic               in_acc;
  logic               emit;

  lane_t              counter_r;
  logic               started_r;
  logic [POS_W-1:0]   pos_r;
  lane_t              ctr_used;

  logic [WORD_W-1:0]  data_r;
  logic [COUNT_W-1:0] count_r;
  logic               last_r;

  logic               out_valid_r;
  logic [WORD_W-1:0]  out_word_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;

  logic [15:0][31:0]  init_words;
  logic [WORD_W-1:0]  ks_word;
  logic [WORD_W-1:0]  mask;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      start_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_KEY0:   key_r[0]   <= cfg_ch.data;
        CFG_KEY1:   key_r[1]   <= cfg_ch.data;
        CFG_KEY2:   key_r[2]   <= cfg_ch.data;
        CFG_KEY3:   key_r[3]   <= cfg_ch.data;
        CFG_NONCE0: nonce_lo_r <= cfg_ch.data;
        CFG_NONCE1: nonce_hi_r <= cfg_ch.data[LANE_W-1:0];
        CFG_START:  start_r    <= cfg_ch.data[LANE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // initial block state
  assign ctr_used = started_r ? counter_r : start_r;

  always_comb begin
    init_words[0]  = SIGMA0;
    init_words[1]  = SIGMA1;
    init_words[2]  = SIGMA2;
    init_words[3]  = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_words[4 + 2*i] = key_r[i][LANE_W-1:0];
      init_words[5 + 2*i] = key_r[i][WORD_W-1:LANE_W];
    end
    init_words[12] = ctr_used;
    init_words[13] = nonce_lo_r[LANE_W-1:0];
    init_words[14] = nonce_lo_r[WORD_W-1:LANE_W];
    init_words[15] = nonce_hi_r;
  end

  chacha_block u_block (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .init_words(init_words),
    .pos       (pos_r),
    .stat      (stat),
    .ks_word   (ks_word)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (pos_r == '0) begin
            ctrl.load = 1'b1;
            state_nxt = ST_ROUND;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ROUND: begin
        ctrl.step = 1'b1;
        if (stat.last_step) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        ctrl.add  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid & in_ready;

  // held request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r  <= in_ch.data_word;
      count_r <= in_ch.byte_count;
      last_r  <= in_ch.last_word;
    end
  end

  // stream position and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      started_r <= 1'b0;
      pos_r     <= '0;
    end else begin
      if (in_acc && !started_r) begin
        counter_r <= start_r;
        started_r <= 1'b1;
      end
      if (ctrl.add) begin
        counter_r <= counter_r + 32'd1;
      end
      if (emit) begin
        if (last_r) begin
          pos_r     <= '0;
          started_r <= 1'b0;
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
    end
  end

  // byte mask from the valid count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = {8{count_r > COUNT_W'(i)}};
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r  <= (data_r ^ ks_word) & mask;
      out_count_r <= count_r;
      out_last_r  <= last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_word       = out_word_r;
  assign out_ch.out_byte_count = out_count_r;
  assign out_ch.out_last       = out_last_r;

endmodule
`default_nettype wire

/* test/tb_top.sv */
// testbench for chacha20_stream_cipher: directed and random traffic against a predictor
`timescale 1ns / 1ps
module tb_top;
  import chacha_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned WORDS_PER_PHASE = 250;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned SETTLE_CYCLES   = 100;

  localparam logic [2:0] REG_IDX_UNUSED = 3'd7;

  localparam int SET_RANDOM    = 0;
  localparam int SET_ZEROS     = 1;
  localparam int SET_ONES      = 2;
  localparam int SET_NEAR_WRAP = 3;

  localparam logic [31:0] CONST_0 = 32'h6170_7865;
  localparam logic [31:0] CONST_1 = 32'h3320_646e;
  localparam logic [31:0] CONST_2 = 32'h7962_2d32;
  localparam logic [31:0] CONST_3 = 32'h6b20_6574;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        is_last;
  } cipher_word_t;

  logic clk = 1'b0;
  logic rst_n;

  chacha_in_if  in_ch ();
  chacha_out_if out_ch ();
  chacha_cfg_if cfg_ch ();

  chacha20_stream_cipher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] key_reg [4] = '{default: '0};
  logic [63:0] nonce_lo_reg = '0;
  logic [31:0] nonce_hi_reg = '0;
  logic [31:0] start_reg = '0;
  logic [63:0] key_stream [8];
  logic [31:0] mix_w [16];
  logic [31:0] blk_ctr = '0;
  logic [2:0]  word_pos = '0;
  logic        msg_open = 1'b0;

  cipher_word_t expected_words [$];
  int unsigned  mismatches = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  idle_cycles = 0;

  function automatic logic [31:0] rol32(logic [31:0] v, int unsigned k);
    logic [63:0] twice;
    twice = {v, v} << k;
    return twice[63:32];
  endfunction

  function automatic void quarter_round(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void refill_keystream();
    logic [31:0] init_w [16];
    init_w[0] = CONST_0;
    init_w[1] = CONST_1;
    init_w[2] = CONST_2;
    init_w[3] = CONST_3;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2 * k] = key_reg[k][31:0];
      init_w[5 + 2 * k] = key_reg[k][63:32];
    end
    init_w[12] = blk_ctr;
    init_w[13] = nonce_lo_reg[31:0];
    init_w[14] = nonce_lo_reg[63:32];
    init_w[15] = nonce_hi_reg;
    for (int k = 0; k < 16; k++) mix_w[k] = init_w[k];
    for (int r = 0; r < 10; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (int k = 0; k < 8; k++)
      key_stream[k] = {mix_w[2 * k + 1] + init_w[2 * k + 1], mix_w[2 * k] + init_w[2 * k]};
  endfunction

  function automatic cipher_word_t encrypt_word(logic [63:0] data, logic [3:0] cnt,
                                                logic is_last);
    cipher_word_t res;
    logic [63:0]  mask;
    if (!msg_open) begin
      blk_ctr  = start_reg;
      msg_open = 1'b1;
    end
    if (word_pos == 3'd0) begin
      refill_keystream();
      blk_ctr = blk_ctr + 32'd1;
    end
    mask = (cnt >= 4'd8) ? '1 : (64'd1 << (8 * cnt)) - 64'd1;
    res.word    = (data ^ key_stream[word_pos]) & mask;
    res.count   = cnt;
    res.is_last = is_last;
    word_pos = word_pos + 3'd1;
    if (is_last) begin
      word_pos = 3'd0;
      msg_open = 1'b0;
    end
    return res;
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [63:0] val);
    case (idx)
      CFG_KEY0:   key_reg[0]   = val;
      CFG_KEY1:   key_reg[1]   = val;
      CFG_KEY2:   key_reg[2]   = val;
      CFG_KEY3:   key_reg[3]   = val;
      CFG_NONCE0: nonce_lo_reg = val;
      CFG_NONCE1: nonce_hi_reg = val[31:0];
      CFG_START:  start_reg    = val[31:0];
      default: ;
    endcase
  endfunction

  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_word  <= data;
    in_ch.byte_count <= cnt;
    in_ch.last_word  <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(encrypt_word(data, cnt, is_last));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg_write(idx, val);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic load_registers(int kind);
    logic [63:0] val;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        SET_ZEROS: val = '0;
        SET_ONES:  val = '1;
        default:   val = {$urandom, $urandom};
      endcase
      if (kind == SET_NEAR_WRAP && 3'(i) == CFG_START)
        val = {$urandom, 32'hffff_ffff - $urandom_range(3)};
      write_reg(3'(i), val);
    end
    cfg_release();
  endtask

  task automatic send_message(int unsigned len, bit noisy);
    logic [3:0] cnt;
    logic       is_last;
    for (int unsigned i = 0; i < len; i++) begin
      is_last = (i == len - 1);
      cnt = is_last ? 4'($urandom_range(8, 1)) : 4'd8;
      if (noisy && $urandom_range(3) == 0) cnt = 4'($urandom_range(15, 0));
      if (noisy && $urandom_range(7) == 0) is_last = 1'b1;
      send_word({$urandom, $urandom}, cnt, is_last);
    end
  endtask

  task automatic test_after_reset();
    send_word(64'h0, 4'd8, 1'b0);
    send_word('1, 4'd8, 1'b1);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    write_reg(CFG_KEY0, 64'h0706_0504_0302_0100);
    write_reg(CFG_KEY1, 64'h0f0e_0d0c_0b0a_0908);
    write_reg(CFG_KEY2, 64'h1716_1514_1312_1110);
    write_reg(CFG_KEY3, 64'h1f1e_1d1c_1b1a_1918);
    write_reg(CFG_NONCE0, 64'h4a00_0000_0900_0000);
    write_reg(CFG_NONCE1, 64'hffff_ffff_0000_0000);
    write_reg(CFG_START, 64'h0000_0000_0000_0001);
    write_reg(REG_IDX_UNUSED, '1);
    cfg_release();
    // zero count, one byte, short word mid-message, counts above eight
    send_word('1, 4'd0, 1'b0);
    send_word('1, 4'd1, 1'b0);
    send_word(64'h0123_4567_89ab_cdef, 4'd7, 1'b0);
    send_word(64'haaaa_aaaa_aaaa_aaaa, 4'd9, 1'b0);
    send_word(64'h5555_5555_5555_5555, 4'd15, 1'b0);
    send_word('1, 4'd8, 1'b1);
    wait_drained();
  endtask

  task automatic test_counter_wrap();
    load_registers(SET_ONES);
    for (int i = 0; i < 9; i++) send_word({$urandom, $urandom}, 4'd8, i == 8);
    wait_drained();
  endtask

  task automatic test_config_mid_message();
    write_reg(CFG_START, 64'd5);
    cfg_release();
    send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word({$urandom, $urandom}, 4'd8, 1'b0);
    wait_drained();
    // key and nonce apply from the next block, start counter from the next message
    write_reg(CFG_KEY2, {$urandom, $urandom});
    write_reg(CFG_NONCE1, {$urandom, $urandom});
    write_reg(CFG_START, {$urandom, $urandom});
    cfg_release();
    for (int i = 0; i < 7; i++) send_word({$urandom, $urandom}, 4'd8, i == 6);
    send_word({$urandom, $urandom}, 4'd3, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      case (phase)
        1: load_registers(SET_ZEROS);
        2: load_registers(SET_ONES);
        5: load_registers(SET_NEAR_WRAP);
        default: load_registers(SET_RANDOM);
      endcase
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(20, 1);
        send_message(len, $urandom_range(99) < 15);
        sent += len;
      end
      wait_drained();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cipher_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none got %h/%0d/%0b", $time,
                 out_ch.out_word, out_ch.out_byte_count, out_ch.out_last);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.out_word !== want.word) begin
          mismatches++;
          $display("%0t: out_word expected %h got %h", $time, want.word, out_ch.out_word);
        end
        if (out_ch.out_byte_count !== want.count) begin
          mismatches++;
          $display("%0t: out_byte_count expected %0d got %0d", $time, want.count,
                   out_ch.out_byte_count);
        end
        if (out_ch.out_last !== want.is_last) begin
          mismatches++;
          $display("%0t: out_last expected %0b got %0b", $time, want.is_last,
                   out_ch.out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no request accepted for %0d cycles", $time, idle_cycles);
      $display("chacha20_stream_cipher test failed");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_word   = '0;
    in_ch.byte_count  = '0;
    in_ch.last_word   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_field_extremes();
    test_counter_wrap();
    test_config_mid_message();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("chacha20_stream_cipher test passed");
    end else begin
      $display("chacha20_stream_cipher test failed");
    end
    $finish;
  end

endmodule
